// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FFHA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define FFHA_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define FFHA_ASSERT(lbl, clk, rstn, prop)
`define FFHA_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ===== rtl/ffha_pkg.sv =====
package ffha_pkg;

  localparam int unsigned HEADER_BYTES = 9;
  localparam int unsigned HDR_BITS     = 8 * HEADER_BYTES;
  localparam logic [7:0]  FLAG_FREE    = 8'd1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_REPORT  = 2'd2,
    OP_REINIT  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_LOAD_CUR,
    CMD_LOAD_NB,
    CMD_STORE_CUR,
    CMD_STORE_REST,
    CMD_SPLIT,
    CMD_STEP,
    CMD_ADVANCE,
    CMD_MERGE,
    CMD_SET_FREE,
    CMD_CLR_FREE,
    CMD_INIT_CUR,
    CMD_ACCUM,
    CMD_RESTART,
    CMD_FINISH
  } cmd_e;

  typedef enum logic [1:0] {
    FIN_OK,
    FIN_ERR,
    FIN_GRANT,
    FIN_SUM
  } fin_e;

  typedef struct packed {
    cmd_e op;
    fin_e fin;
  } dp_cmd_t;

  typedef struct packed {
    logic xfer_done;
    logic cur_free;
    logic nb_free;
    logic fits;
    logic split_ok;
    logic next_zero;
    logic guard_hit;
    logic grant_big;
    logic addr_small;
    logic at_target;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_BOOT,
    S_BOOT_ST,
    S_BOOT_W,
    S_IDLE,
    S_AL_LD,
    S_AL_W,
    S_AL_TST,
    S_AL_RW,
    S_AL_MARK,
    S_AL_ST,
    S_AL_SW,
    S_RL_CHK,
    S_RL_LD,
    S_RL_W,
    S_RL_TST,
    S_RL_ST,
    S_RL_SW,
    S_MG_LD,
    S_MG_W,
    S_MG_TST,
    S_MG_NW,
    S_MG_DEC,
    S_MG_ST,
    S_MG_SW,
    S_RP_LD,
    S_RP_W,
    S_RP_ACC,
    S_RP_TST,
    S_RI_ST,
    S_RI_SW
  } state_e;

endpackage

// ===== rtl/ffha_ram.sv =====
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/ffha_ctrl.sv =====
module ffha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         operation_i,
  input  ffha_pkg::dp_stat_t stat_i,
  output ffha_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);

  ffha_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::S_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ffha_pkg::S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = ffha_pkg::CMD_NONE;
    cmd_o.fin = ffha_pkg::FIN_OK;
    unique case (state_q)
      ffha_pkg::S_BOOT: begin
        cmd_o.op = ffha_pkg::CMD_INIT_CUR;
        state_d  = ffha_pkg::S_BOOT_ST;
      end
      ffha_pkg::S_BOOT_ST: begin
        cmd_o.op = ffha_pkg::CMD_STORE_CUR;
        state_d  = ffha_pkg::S_BOOT_W;
      end
      ffha_pkg::S_BOOT_W: begin
        if (stat_i.xfer_done) state_d = ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.op = ffha_pkg::CMD_LATCH;
          unique case (ffha_pkg::op_e'(operation_i))
            ffha_pkg::OP_ALLOC:   state_d = ffha_pkg::S_AL_LD;
            ffha_pkg::OP_RELEASE: state_d = ffha_pkg::S_RL_CHK;
            ffha_pkg::OP_REPORT:  state_d = ffha_pkg::S_RP_LD;
            ffha_pkg::OP_REINIT: begin
              cmd_o.op = ffha_pkg::CMD_INIT_CUR;
              state_d  = ffha_pkg::S_RI_ST;
            end
            default: state_d = ffha_pkg::S_IDLE;
          endcase
        end
      end
      // allocate
      ffha_pkg::S_AL_LD: begin
        cmd_o.op = ffha_pkg::CMD_LOAD_CUR;
        state_d  = ffha_pkg::S_AL_W;
      end
      ffha_pkg::S_AL_W: begin
        if (stat_i.xfer_done) state_d = ffha_pkg::S_AL_TST;
      end
      ffha_pkg::S_AL_TST: begin
        priority if (!(stat_i.cur_free && stat_i.fits) && !stat_i.next_zero &&
                     !stat_i.guard_hit) begin
          cmd_o.op = ffha_pkg::CMD_STEP;
          state_d  = ffha_pkg::S_AL_LD;
        end else if (!(stat_i.cur_free && stat_i.fits) || stat_i.grant_big) begin
          cmd_o.op  = ffha_pkg::CMD_FINISH;
          cmd_o.fin = ffha_pkg::FIN_ERR;
          state_d   = ffha_pkg::S_IDLE;
        end else if (stat_i.split_ok) begin
          cmd_o.op = ffha_pkg::CMD_STORE_REST;
          state_d  = ffha_pkg::S_AL_RW;
        end else begin
          state_d = ffha_pkg::S_AL_MARK;
        end
      end
      ffha_pkg::S_AL_RW: begin
        if (stat_i.xfer_done) begin
          cmd_o.op = ffha_pkg::CMD_SPLIT;
          state_d  = ffha_pkg::S_AL_MARK;
        end
      end
      ffha_pkg::S_AL_MARK: begin
        cmd_o.op = ffha_pkg::CMD_CLR_FREE;
        state_d  = ffha_pkg::S_AL_ST;
      end
      ffha_pkg::S_AL_ST: begin
        cmd_o.op = ffha_pkg::CMD_STORE_CUR;
        state_d  = ffha_pkg::S_AL_SW;
      end
      ffha_pkg::S_AL_SW: begin
        if (stat_i.xfer_done) begin
          cmd_o.op  = ffha_pkg::CMD_FINISH;
          cmd_o.fin = ffha_pkg::FIN_GRANT;
          state_d   = ffha_pkg::S_IDLE;
        end
      end
      // release
      ffha_pkg::S_RL_CHK: begin
        if (stat_i.addr_small) begin
          cmd_o.op  = ffha_pkg::CMD_FINISH;
          cmd_o.fin = ffha_pkg::FIN_ERR;
          state_d   = ffha_pkg::S_IDLE;
        end else begin
          state_d = ffha_pkg::S_RL_LD;
        end
      end
      ffha_pkg::S_RL_LD: begin
        cmd_o.op = ffha_pkg::CMD_LOAD_CUR;
        state_d  = ffha_pkg::S_RL_W;
      end
      ffha_pkg::S_RL_W: begin
        if (stat_i.xfer_done) state_d = ffha_pkg::S_RL_TST;
      end
      ffha_pkg::S_RL_TST: begin
        priority if (!stat_i.at_target && !stat_i.next_zero && !stat_i.guard_hit) begin
          cmd_o.op = ffha_pkg::CMD_STEP;
          state_d  = ffha_pkg::S_RL_LD;
        end else if (!stat_i.at_target) begin
          cmd_o.op  = ffha_pkg::CMD_FINISH;
          cmd_o.fin = ffha_pkg::FIN_ERR;
          state_d   = ffha_pkg::S_IDLE;
        end else begin
          cmd_o.op = ffha_pkg::CMD_SET_FREE;
          state_d  = ffha_pkg::S_RL_ST;
        end
      end
      ffha_pkg::S_RL_ST: begin
        cmd_o.op = ffha_pkg::CMD_STORE_CUR;
        state_d  = ffha_pkg::S_RL_SW;
      end
      ffha_pkg::S_RL_SW: begin
        if (stat_i.xfer_done) begin
          cmd_o.op = ffha_pkg::CMD_RESTART;
          state_d  = ffha_pkg::S_MG_LD;
        end
      end
      // coalesce
      ffha_pkg::S_MG_LD: begin
        cmd_o.op = ffha_pkg::CMD_LOAD_CUR;
        state_d  = ffha_pkg::S_MG_W;
      end
      ffha_pkg::S_MG_W: begin
        if (stat_i.xfer_done) state_d = ffha_pkg::S_MG_TST;
      end
      ffha_pkg::S_MG_TST: begin
        if (stat_i.next_zero || stat_i.guard_hit) begin
          cmd_o.op  = ffha_pkg::CMD_FINISH;
          cmd_o.fin = ffha_pkg::FIN_OK;
          state_d   = ffha_pkg::S_IDLE;
        end else begin
          cmd_o.op = ffha_pkg::CMD_LOAD_NB;
          state_d  = ffha_pkg::S_MG_NW;
        end
      end
      ffha_pkg::S_MG_NW: begin
        if (stat_i.xfer_done) state_d = ffha_pkg::S_MG_DEC;
      end
      ffha_pkg::S_MG_DEC: begin
        if (stat_i.cur_free && stat_i.nb_free) begin
          cmd_o.op = ffha_pkg::CMD_MERGE;
          state_d  = ffha_pkg::S_MG_ST;
        end else begin
          cmd_o.op = ffha_pkg::CMD_ADVANCE;
          state_d  = ffha_pkg::S_MG_TST;
        end
      end
      ffha_pkg::S_MG_ST: begin
        cmd_o.op = ffha_pkg::CMD_STORE_CUR;
        state_d  = ffha_pkg::S_MG_SW;
      end
      ffha_pkg::S_MG_SW: begin
        if (stat_i.xfer_done) state_d = ffha_pkg::S_MG_TST;
      end
      // report
      ffha_pkg::S_RP_LD: begin
        cmd_o.op = ffha_pkg::CMD_LOAD_CUR;
        state_d  = ffha_pkg::S_RP_W;
      end
      ffha_pkg::S_RP_W: begin
        if (stat_i.xfer_done) state_d = ffha_pkg::S_RP_ACC;
      end
      ffha_pkg::S_RP_ACC: begin
        cmd_o.op = ffha_pkg::CMD_ACCUM;
        state_d  = ffha_pkg::S_RP_TST;
      end
      ffha_pkg::S_RP_TST: begin
        if (stat_i.next_zero || stat_i.guard_hit) begin
          cmd_o.op  = ffha_pkg::CMD_FINISH;
          cmd_o.fin = ffha_pkg::FIN_SUM;
          state_d   = ffha_pkg::S_IDLE;
        end else begin
          state_d = ffha_pkg::S_RP_LD;
        end
      end
      // reinit
      ffha_pkg::S_RI_ST: begin
        cmd_o.op = ffha_pkg::CMD_STORE_CUR;
        state_d  = ffha_pkg::S_RI_SW;
      end
      ffha_pkg::S_RI_SW: begin
        if (stat_i.xfer_done) begin
          cmd_o.op  = ffha_pkg::CMD_FINISH;
          cmd_o.fin = ffha_pkg::FIN_OK;
          state_d   = ffha_pkg::S_IDLE;
        end
      end
      default: state_d = ffha_pkg::S_BOOT;
    endcase
  end

endmodule

// ===== rtl/ffha_dp.sv =====
module ffha_dp #(
  parameter int unsigned HEAP_BYTES = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ffha_pkg::dp_cmd_t  cmd_i,
  input  logic [15:0]        request_size_i,
  input  logic [15:0]        block_address_i,
  output ffha_pkg::dp_stat_t stat_o,
  output logic               result_valid_o,
  output logic [15:0]        granted_address_o,
  output logic [15:0]        free_bytes_o,
  output logic               status_o
);

  localparam int unsigned AW         = $clog2(HEAP_BYTES);
  localparam int unsigned WALK_LIMIT = 2 * (HEAP_BYTES / 9) + 4;
  localparam int unsigned GW         = $clog2(WALK_LIMIT + 1);
  localparam logic [31:0] HEAP_W     = 32'(HEAP_BYTES);
  localparam logic [31:0] HDR_W      = 32'(ffha_pkg::HEADER_BYTES);
  localparam logic [3:0]  LAST_BYTE  = 4'(ffha_pkg::HEADER_BYTES - 1);
  localparam logic [3:0]  LOAD_END   = 4'(ffha_pkg::HEADER_BYTES);

  logic [15:0] want_q, target_q;
  logic        addr_small_q;
  logic [31:0] a_q;
  logic        cur_free_q, nb_free_q;
  logic [31:0] cur_size_q, cur_next_q, nb_size_q, nb_next_q;
  logic [GW-1:0] guard_q;
  logic [15:0] sum_q;

  logic        xf_act_q, xf_store_q, xf_nb_q, xf_oob_q;
  logic [3:0]  xf_cnt_q;
  logic [31:0] xf_base_q;
  logic [ffha_pkg::HDR_BITS-1:0] xf_buf_q, ld_buf;

  logic        res_valid_q, st_q;
  logic [15:0] grant_q, fb_q;

  logic [31:0] byte_addr, rest_addr, acc_sum;
  logic        in_range, xfer_done, ram_we;
  logic [7:0]  rdata, rd_byte;

  assign byte_addr = xf_base_q + {28'd0, xf_cnt_q};
  assign in_range  = byte_addr < HEAP_W;
  assign rest_addr = a_q + HDR_W + {16'd0, want_q};
  assign acc_sum   = {16'd0, sum_q} + cur_size_q;
  assign rd_byte   = xf_oob_q ? 8'd0 : rdata;
  assign ld_buf    = {rd_byte, xf_buf_q[ffha_pkg::HDR_BITS-1:8]};
  assign xfer_done = xf_act_q && (xf_store_q ? (xf_cnt_q == LAST_BYTE)
                                             : (xf_cnt_q == LOAD_END));
  assign ram_we    = xf_act_q && xf_store_q && in_range;

  ffha_ram #(
    .WIDTH (8),
    .DEPTH (HEAP_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (byte_addr[AW-1:0]),
    .wdata_i (xf_buf_q[7:0]),
    .rdata_o (rdata)
  );

  assign stat_o.xfer_done  = xfer_done;
  assign stat_o.cur_free   = cur_free_q;
  assign stat_o.nb_free    = nb_free_q;
  assign stat_o.fits       = cur_size_q >= {16'd0, want_q};
  assign stat_o.split_ok   = cur_size_q > ({16'd0, want_q} + HDR_W);
  assign stat_o.next_zero  = (cur_next_q == 32'd0);
  assign stat_o.guard_hit  = guard_q >= GW'(WALK_LIMIT);
  assign stat_o.grant_big  = (a_q + HDR_W) > 32'h0000_FFFF;
  assign stat_o.addr_small = addr_small_q;
  assign stat_o.at_target  = (a_q == {16'd0, target_q});

  // Control: transfer engine and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xf_act_q    <= 1'b0;
      xf_cnt_q    <= 4'd0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.op == ffha_pkg::CMD_FINISH);
      if (xfer_done) begin
        xf_act_q <= 1'b0;
      end else if (xf_act_q) begin
        xf_cnt_q <= xf_cnt_q + 4'd1;
      end
      if (cmd_i.op == ffha_pkg::CMD_LOAD_CUR || cmd_i.op == ffha_pkg::CMD_LOAD_NB ||
          cmd_i.op == ffha_pkg::CMD_STORE_CUR || cmd_i.op == ffha_pkg::CMD_STORE_REST) begin
        xf_act_q <= 1'b1;
        xf_cnt_q <= 4'd0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    xf_oob_q <= !in_range;
    if (xf_act_q && !xfer_done) begin
      xf_buf_q <= xf_store_q ? (xf_buf_q >> 8) : (xf_cnt_q != 4'd0 ? ld_buf : xf_buf_q);
    end
    if (xfer_done && !xf_store_q) begin
      if (xf_nb_q) begin
        nb_free_q <= (ld_buf[7:0] == ffha_pkg::FLAG_FREE);
        nb_size_q <= ld_buf[39:8];
        nb_next_q <= ld_buf[71:40];
      end else begin
        cur_free_q <= (ld_buf[7:0] == ffha_pkg::FLAG_FREE);
        cur_size_q <= ld_buf[39:8];
        cur_next_q <= ld_buf[71:40];
      end
    end
    unique case (cmd_i.op)
      ffha_pkg::CMD_LATCH: begin
        want_q       <= request_size_i;
        target_q     <= block_address_i - 16'(ffha_pkg::HEADER_BYTES);
        addr_small_q <= block_address_i < 16'(ffha_pkg::HEADER_BYTES);
        a_q          <= 32'd0;
        guard_q      <= '0;
        sum_q        <= 16'd0;
      end
      ffha_pkg::CMD_LOAD_CUR: begin
        xf_store_q <= 1'b0;
        xf_nb_q    <= 1'b0;
        xf_base_q  <= a_q;
      end
      ffha_pkg::CMD_LOAD_NB: begin
        xf_store_q <= 1'b0;
        xf_nb_q    <= 1'b1;
        xf_base_q  <= cur_next_q;
        guard_q    <= guard_q + GW'(1);
      end
      ffha_pkg::CMD_STORE_CUR: begin
        xf_store_q <= 1'b1;
        xf_nb_q    <= 1'b0;
        xf_base_q  <= a_q;
        xf_buf_q   <= {cur_next_q, cur_size_q, 7'd0, cur_free_q};
      end
      ffha_pkg::CMD_STORE_REST: begin
        xf_store_q <= 1'b1;
        xf_nb_q    <= 1'b0;
        xf_base_q  <= rest_addr;
        xf_buf_q   <= {cur_next_q, cur_size_q - {16'd0, want_q} - HDR_W,
                       ffha_pkg::FLAG_FREE};
      end
      ffha_pkg::CMD_SPLIT: begin
        cur_size_q <= {16'd0, want_q};
        cur_next_q <= rest_addr;
      end
      ffha_pkg::CMD_STEP: begin
        a_q     <= cur_next_q;
        guard_q <= guard_q + GW'(1);
      end
      ffha_pkg::CMD_ADVANCE: begin
        a_q        <= cur_next_q;
        cur_free_q <= nb_free_q;
        cur_size_q <= nb_size_q;
        cur_next_q <= nb_next_q;
      end
      ffha_pkg::CMD_MERGE: begin
        cur_size_q <= cur_size_q + nb_size_q + HDR_W;
        cur_next_q <= nb_next_q;
      end
      ffha_pkg::CMD_SET_FREE: cur_free_q <= 1'b1;
      ffha_pkg::CMD_CLR_FREE: cur_free_q <= 1'b0;
      ffha_pkg::CMD_INIT_CUR: begin
        a_q        <= 32'd0;
        cur_free_q <= 1'b1;
        cur_size_q <= HEAP_W - HDR_W;
        cur_next_q <= 32'd0;
      end
      ffha_pkg::CMD_ACCUM: begin
        if (cur_free_q) begin
          sum_q <= (acc_sum > 32'h0000_FFFF) ? 16'hFFFF : acc_sum[15:0];
        end
        a_q     <= cur_next_q;
        guard_q <= guard_q + GW'(1);
      end
      ffha_pkg::CMD_RESTART: begin
        a_q     <= 32'd0;
        guard_q <= '0;
      end
      ffha_pkg::CMD_FINISH: begin
        grant_q <= (cmd_i.fin == ffha_pkg::FIN_GRANT) ? (a_q[15:0] + HDR_W[15:0]) : 16'd0;
        fb_q    <= (cmd_i.fin == ffha_pkg::FIN_SUM) ? sum_q : 16'd0;
        st_q    <= (cmd_i.fin == ffha_pkg::FIN_ERR);
      end
      default: ;
    endcase
  end

  assign result_valid_o    = res_valid_q;
  assign granted_address_o = grant_q;
  assign free_bytes_o      = fb_q;
  assign status_o          = st_q;

endmodule

// ===== rtl/first_fit_heap_allocator_top.sv =====
// Channel  | Direction | Handshake               | Beat contents
// ---------+-----------+-------------------------+----------------------------------------
// command  | in        | start_i high, busy_o low| operation_i, request_size_i,
//          |           |                         | block_address_i
// result   | out       | result_valid_o, 1 cycle | granted_address_o, free_bytes_o, status_o
//
// One command at a time. Every header access moves 9 bytes through the single
// byte-wide heap RAM port. An allocate or release walks the header chain and,
// on success, stores headers; a release also runs a coalescing pass. After
// reset the block writes the initial free header with busy_o high. The
// receiver cannot stall: result_valid_o pulses one cycle, in the cycle after
// the last step of the command, and busy_o drops in that cycle.
`include "assert_macros.svh"

module first_fit_heap_allocator_top #(
  parameter int unsigned HEAP_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] block_address_i,
  output logic        result_valid_o,
  output logic [15:0] granted_address_o,
  output logic [15:0] free_bytes_o,
  output logic        status_o
);

  ffha_pkg::dp_cmd_t  cmd;
  ffha_pkg::dp_stat_t stat;

  // Sequence header walks; besides start_i and operation_i the controller only sees status flags.
  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  // Hold header registers, the heap RAM and the result beat.
  ffha_dp #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .request_size_i    (request_size_i),
    .block_address_i   (block_address_i),
    .stat_o            (stat),
    .result_valid_o    (result_valid_o),
    .granted_address_o (granted_address_o),
    .free_bytes_o      (free_bytes_o),
    .status_o          (status_o)
  );

  // An accepted command keeps the block busy in the following cycle.
  `FFHA_ASSERT(a_start_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o)
  // A result beat only closes a command that was in flight.
  `FFHA_ASSERT(a_result_after_busy, clk_i, rst_ni, result_valid_o |-> $past(busy_o))
  // A failed command never grants an address.
  `FFHA_NEVER(a_err_no_grant, clk_i, rst_ni,
              result_valid_o && status_o && (granted_address_o != 16'd0))
  // A grant always points past a header.
  `FFHA_NEVER(a_grant_low, clk_i, rst_ni,
              result_valid_o && (granted_address_o != 16'd0) && (granted_address_o < 16'd9))

endmodule
